>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent assertions of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hw/rtl/mmbi_pkg.sv
// ----------------------------------------------------------------------------
// Mid-month bin interpolation package
// Transaction types, month codes and the constant calendar tables.
// ----------------------------------------------------------------------------
package mmbi_pkg;

  // Input transaction: one calendar date.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } in_t;

  // Output transaction: bracketing bins and interpolation weight.
  typedef struct packed {
    logic [4:0]  days_to_center;
    logic [3:0]  current_month;
    logic [3:0]  previous_month;
    logic [16:0] weight_q16;
  } out_t;

  // Month codes.
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthDec = 4'd12;

  // Multiplicative inverse of 25 modulo 2^14, and the largest product that
  // marks an exact multiple of 25.
  localparam logic [13:0] Inv25      = 14'd7209;
  localparam logic [13:0] Div25Limit = 14'(16383 / 25);

  // Late December window length in days, and the wrap distance.
  localparam logic [8:0] LateDecSpan = 9'd16;
  localparam logic [8:0] WrapDays    = 9'd31;

  // Reciprocal of 30.5 scaled for Q16 output: ceil(2^29 / 61), used as
  // (days * WeightMul) >> 12.
  localparam int unsigned WeightShift = 12;
  localparam logic [23:0] WeightMul   = 24'(((1 << 29) + 60) / 61);

  // Days before the first of the month in a common year; leap years add one
  // from March onwards.
  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] month);
    logic [8:0] base;
    base = 9'd0;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (month >= MonthMar)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Day of year of each mid-month centre in a common year; leap years add one
  // from March onwards.
  function automatic logic [8:0] bin_center(input logic leap, input logic [3:0] month);
    logic [8:0] base;
    base = 9'd0;
    case (month)
      4'd1:    base = 9'd15;
      4'd2:    base = 9'd46;
      4'd3:    base = 9'd74;
      4'd4:    base = 9'd105;
      4'd5:    base = 9'd135;
      4'd6:    base = 9'd166;
      4'd7:    base = 9'd196;
      4'd8:    base = 9'd227;
      4'd9:    base = 9'd258;
      4'd10:   base = 9'd288;
      4'd11:   base = 9'd319;
      4'd12:   base = 9'd349;
      default: base = 9'd0;
    endcase
    if (leap && (month >= MonthMar)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

>>> hw/rtl/mmbi_leap.sv
// ----------------------------------------------------------------------------
// Gregorian leap year detector
// Decides the leap rule for a 14-bit year without a divider.
// ----------------------------------------------------------------------------
module mmbi_leap (
  input  logic [13:0] year_i,
  output logic        leap_o
);

  logic [13:0] inv_prod;
  logic        div25;
  logic        div4;
  logic        div16;

  // A year is a multiple of 25 exactly when its product with the inverse of
  // 25 modulo 2^14 falls at or below (2^14 - 1) / 25.
  assign inv_prod = year_i * mmbi_pkg::Inv25;
  assign div25    = (inv_prod <= mmbi_pkg::Div25Limit);

  // Powers of two come straight from the low bits.
  assign div4  = (year_i[1:0] == 2'b00);
  assign div16 = (year_i[3:0] == 4'b0000);

  // Divisible by 100 is div4 with div25; divisible by 400 is div16 with div25.
  assign leap_o = (div4 && !div25) || (div16 && div25);

endmodule

>>> hw/rtl/mmbi_bin.sv
// ----------------------------------------------------------------------------
// Mid-month bin search
// Finds the bracketing bins, the days to the next centre and the Q16 weight.
// ----------------------------------------------------------------------------
module mmbi_bin (
  input  logic              leap_i,
  input  logic [3:0]        month_i,
  input  logic [4:0]        day_i,
  output mmbi_pkg::out_t    result_o
);

  logic [3:0]        month_c;
  logic [8:0]        doy;
  logic [8:0]        center_m;
  logic [8:0]        center_cur;
  logic [8:0]        center_dec;
  logic [3:0]        cur_month;
  logic [3:0]        pre_month;
  logic              late_dec;
  logic signed [9:0] delta;
  logic [4:0]        days;
  logic [28:0]       weight_prod;

  // Clamp out-of-range months onto January and December.
  always_comb begin
    if (month_i < mmbi_pkg::MonthJan) begin
      month_c = mmbi_pkg::MonthJan;
    end else if (month_i > mmbi_pkg::MonthDec) begin
      month_c = mmbi_pkg::MonthDec;
    end else begin
      month_c = month_i;
    end
  end

  // Day of year and the centre of the date's own month.
  assign doy      = mmbi_pkg::days_before(leap_i, month_c) + 9'(day_i);
  assign center_m = mmbi_pkg::bin_center(leap_i, month_c);

  // Pick the bin that follows the date, wrapping at the year end.
  always_comb begin
    if (doy <= center_m) begin
      cur_month = month_c;
      pre_month = (month_c == mmbi_pkg::MonthJan) ? mmbi_pkg::MonthDec
                                                  : month_c - 4'd1;
    end else begin
      cur_month = (month_c == mmbi_pkg::MonthDec) ? mmbi_pkg::MonthJan
                                                  : month_c + 4'd1;
      pre_month = month_c;
    end
  end

  assign center_cur = mmbi_pkg::bin_center(leap_i, cur_month);
  assign center_dec = mmbi_pkg::bin_center(leap_i, mmbi_pkg::MonthDec);

  // Late December counts towards the January centre of the next year.
  assign late_dec = (pre_month == mmbi_pkg::MonthDec) && (doy > center_dec) &&
                    (doy <= center_dec + mmbi_pkg::LateDecSpan);

  always_comb begin
    if (late_dec) begin
      delta = $signed({1'b0, mmbi_pkg::WrapDays}) - $signed({1'b0, doy})
              + $signed({1'b0, center_dec});
    end else begin
      delta = $signed({1'b0, center_cur}) - $signed({1'b0, doy});
    end
  end

  // Saturate the distance to the 5-bit range.
  always_comb begin
    if (delta < 10'sd0) begin
      days = 5'd0;
    end else if (delta > 10'sd31) begin
      days = 5'd31;
    end else begin
      days = delta[4:0];
    end
  end

  // Weight = floor(days * 2^17 / 61) by reciprocal multiplication.
  assign weight_prod = 29'(days) * 29'(mmbi_pkg::WeightMul);

  assign result_o.days_to_center = days;
  assign result_o.current_month  = cur_month;
  assign result_o.previous_month = pre_month;
  assign result_o.weight_q16     = weight_prod[28:mmbi_pkg::WeightShift];

endmodule

>>> hw/rtl/mid_month_bin_interpolation.sv
// ----------------------------------------------------------------------------
// Mid-month bin interpolation
// Maps a calendar date onto its bracketing monthly bins with a Q16 weight.
// ----------------------------------------------------------------------------
// The block accepts one date transaction per clock cycle while in_stall_o is
// low, and a result is taken into the result register after its date has
// passed through the input register: the leap rule is settled as the date
// enters the input register, and the bin search with the weight multiplier
// sits between the input register and the result register. A stall on the
// output backs up through both registers, so a held result does not stop a
// new date from being taken while the input register is free.
module mid_month_bin_interpolation (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mmbi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mmbi_pkg::out_t out_data_o
);

`include "assert_macros.svh"

  logic           leap_in;
  logic           s1_valid_q;
  logic           s1_leap_q;
  logic [3:0]     s1_month_q;
  logic [4:0]     s1_day_q;
  logic           out_valid_q;
  mmbi_pkg::out_t out_data_q;
  mmbi_pkg::out_t result;
  logic           out_free;
  logic           s1_free;

  // Leap detection on the incoming year.
  mmbi_leap u_leap (
    .year_i (in_data_i.year),
    .leap_o (leap_in)
  );

  // Flow control: each register takes new data when empty or draining.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_leap_q  <= leap_in;
      s1_month_q <= in_data_i.month;
      s1_day_q   <= in_data_i.day;
    end
  end

  // Bin search and weight.
  mmbi_bin u_bin (
    .leap_i   (s1_leap_q),
    .month_i  (s1_month_q),
    .day_i    (s1_day_q),
    .result_o (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A stall on the input side only arises with both registers occupied.
  `ASSERT_PROP(a_stall_full, clk_i, rst_ni, in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))

  // An accepted date always lands in the input register.
  `ASSERT_PROP(a_accept_lands, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> s1_valid_q)

  // The two reported bins are always neighbouring months.
  `ASSERT_PROP(a_bins_adjacent, clk_i, rst_ni, out_valid_o |-> ((out_data_o.previous_month == mmbi_pkg::MonthDec) ? (out_data_o.current_month == mmbi_pkg::MonthJan) : (out_data_o.current_month == out_data_o.previous_month + 4'd1)))

  // A zero weight goes with zero days and only then.
  `ASSERT_PROP(a_weight_zero, clk_i, rst_ni, out_valid_o |-> ((out_data_o.weight_q16 == 17'd0) == (out_data_o.days_to_center == 5'd0)))

endmodule

>>> sim/mid_month_bin_interpolation_tb.sv
// ----------------------------------------------------------------------------
// Mid-month bin interpolation testbench
// Sends calendar dates through the valid/stall input channel and checks each
// result transaction against a date-to-bin predictor kept in the testbench.
// Directed dates cover the year, month and day extremes, leap rules and late
// December. Random dates follow, with random idling on both channels, one long
// receiver hold-off and two pauses of the sender until the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mid_month_bin_interpolation_tb;

  localparam int RandomDates = 1850;
  localparam int TailDates   = 150;
  localparam int HoldAfter   = 400;
  localparam int HoldCycles  = 60;
  localparam int CycleLimit  = 200000;
  localparam int JanNo       = int'(mmbi_pkg::MonthJan);
  localparam int MarNo       = int'(mmbi_pkg::MonthMar);
  localparam int DecNo       = int'(mmbi_pkg::MonthDec);

  // Calendar tables, index 0 for common and 1 for leap years.
  localparam int CumDays [2][13] = '{
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334},
    '{0, 0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335}};
  localparam int MidDoy [2][13] = '{
    '{0, 15, 46, 74, 105, 135, 166, 196, 227, 258, 288, 319, 349},
    '{0, 15, 46, 75, 106, 136, 167, 197, 228, 259, 289, 320, 350}};
  localparam int MonthLen [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    mmbi_pkg::in_t date;
    bit            quiesce;  // hold this date back until every result has arrived
  } pending_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall_o;
  mmbi_pkg::in_t  in_data = '0;
  logic           out_valid_o;
  logic           out_stall = 1'b0;
  mmbi_pkg::out_t out_data_o;

  pending_t       pending_dates[$];
  pending_t       next_item;
  mmbi_pkg::out_t due_bins[$];
  mmbi_pkg::out_t want;
  logic           in_fire = 1'b0;
  int             mismatches = 0;
  int             results_seen = 0;
  int             cycles = 0;
  int             src_gap = 0;
  int             src_phase = 0;
  bit             src_calm = 1'b0;
  int             snk_gap = 0;
  int             snk_phase = 0;
  bit             snk_calm = 1'b0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;

  mid_month_bin_interpolation i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Gregorian leap rule; year zero counts as a multiple of 400.
  function automatic int is_leap(int y);
    return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 1 : 0;
  endfunction

  // Works out the bracketing bins, the days to the next centre and the weight.
  function automatic mmbi_pkg::out_t bin_of_date(mmbi_pkg::in_t d);
    int             lp;
    int             mon;
    int             cur;
    int             prv;
    int             doy;
    int             dd;
    int             dec_mid;
    mmbi_pkg::out_t r;
    lp  = is_leap(int'(d.year));
    mon = int'(d.month);
    if (mon < JanNo) mon = JanNo;
    if (mon > DecNo) mon = DecNo;
    doy = CumDays[lp][mon] + int'(d.day);
    if (doy <= MidDoy[lp][mon]) begin
      cur = mon;
      prv = (mon == JanNo) ? DecNo : mon - 1;
    end else begin
      cur = (mon == DecNo) ? JanNo : mon + 1;
      prv = mon;
    end
    dd = MidDoy[lp][cur] - doy;
    // Late December counts towards the January centre of the next year.
    dec_mid = MidDoy[lp][DecNo];
    if (prv == DecNo && doy > dec_mid && doy <= dec_mid + 16) begin
      dd = 31 - (doy - dec_mid);
    end
    if (dd < 0) dd = 0;
    if (dd > 31) dd = 31;
    r.days_to_center = 5'(dd);
    r.current_month  = 4'(cur);
    r.previous_month = 4'(prv);
    r.weight_q16     = 17'((dd * 131072) / 61);
    return r;
  endfunction

  task automatic queue_date(input int y, input int m, input int d, input bit q);
    pending_t p;
    p.date.year  = 14'(y);
    p.date.month = 4'(m);
    p.date.day   = 5'(d);
    p.quiesce    = q;
    pending_dates.push_back(p);
  endtask

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** mid_month_bin_interpolation: FAILED **");
      $finish;
    end
  end

  // Monitor: records accepted dates and checks each result transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        results_seen <= results_seen + 1;
        if (due_bins.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_data_o);
          mismatches++;
        end else begin
          want = due_bins.pop_front();
          if (out_data_o.days_to_center !== want.days_to_center) begin
            $error("days_to_center: expected %0d, got %0d",
                   want.days_to_center, out_data_o.days_to_center);
            mismatches++;
          end
          if (out_data_o.current_month !== want.current_month) begin
            $error("current_month: expected %0d, got %0d",
                   want.current_month, out_data_o.current_month);
            mismatches++;
          end
          if (out_data_o.previous_month !== want.previous_month) begin
            $error("previous_month: expected %0d, got %0d",
                   want.previous_month, out_data_o.previous_month);
            mismatches++;
          end
          if (out_data_o.weight_q16 !== want.weight_q16) begin
            $error("weight_q16: expected %0d, got %0d",
                   want.weight_q16, out_data_o.weight_q16);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall_o) begin
        due_bins.push_back(bin_of_date(in_data));
      end
      in_fire <= in_valid && !in_stall_o;
    end
  end

  // Driver: offers the next pending date once the previous one has gone.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (src_phase == 0) begin
        src_calm  = ($urandom_range(0, 2) == 0);
        src_phase = $urandom_range(30, 120);
      end else begin
        src_phase--;
      end
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_dates.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_dates[0].quiesce && due_bins.size() != 0) begin
        in_valid <= 1'b0;
      end else if (!src_calm && pending_dates.size() > TailDates &&
                   $urandom_range(0, 5) == 0) begin
        src_gap  = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        next_item = pending_dates.pop_front();
        in_data  <= next_item.date;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_phase == 0) begin
        snk_calm  = ($urandom_range(0, 2) == 0);
        snk_phase = $urandom_range(30, 120);
      end else begin
        snk_phase--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else if (!snk_calm && pending_dates.size() > TailDates &&
                   $urandom_range(0, 4) == 0) begin
        snk_gap   = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int y;
    int m;
    int d;
    int lim;
    int pick;

    // Directed dates: field extremes, leap rules, wrap and late December.
    queue_date(0, JanNo, 1, 1'b0);
    queue_date(16383, 15, 31, 1'b0);
    queue_date(9999, DecNo, 31, 1'b0);
    queue_date(1, 0, 0, 1'b0);
    queue_date(2000, 2, 29, 1'b0);
    queue_date(1900, 2, 28, 1'b0);
    queue_date(2024, MarNo, 15, 1'b0);
    queue_date(2024, MarNo, 16, 1'b0);
    queue_date(2023, MarNo, 15, 1'b0);
    queue_date(2023, MarNo, 16, 1'b0);
    queue_date(2023, JanNo, 15, 1'b0);
    queue_date(2023, JanNo, 16, 1'b0);
    queue_date(2023, 2, 15, 1'b0);
    queue_date(2023, 2, 16, 1'b0);
    queue_date(2023, DecNo, 15, 1'b0);
    queue_date(2023, DecNo, 16, 1'b0);
    queue_date(2024, DecNo, 16, 1'b0);
    queue_date(2024, DecNo, 17, 1'b0);
    queue_date(2024, DecNo, 31, 1'b0);
    queue_date(2023, DecNo, 0, 1'b0);
    queue_date(2023, 13, 20, 1'b0);
    queue_date(8191, 7, 31, 1'b0);
    queue_date(400, 11, 30, 1'b0);
    queue_date(100, 6, 1, 1'b0);

    // Random dates: mostly valid, some late December, some raw field noise.
    for (int i = 0; i < RandomDates; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        y   = $urandom_range(1, 9999);
        m   = $urandom_range(1, 12);
        lim = MonthLen[m] + ((m == 2) ? is_leap(y) : 0);
        d   = $urandom_range(1, lim);
      end else if (pick < 8) begin
        y = $urandom_range(0, 9999);
        m = DecNo;
        d = $urandom_range(12, 31);
      end else begin
        y = $urandom_range(0, 16383);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end
      queue_date(y, m, d, (i == 0) || (i == RandomDates / 2));
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_dates.size() != 0 || in_valid) @(posedge clk_i);
    while (due_bins.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** mid_month_bin_interpolation: PASSED **");
    end else begin
      $display("** mid_month_bin_interpolation: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mmbi_pkg.sv
hw/rtl/mmbi_leap.sv
hw/rtl/mmbi_bin.sv
hw/rtl/mid_month_bin_interpolation.sv
sim/mid_month_bin_interpolation_tb.sv
